### src/bbi_pkg.sv
// ---------------------------------------------------------------------------
// bbi_pkg
// Types, constants, microcode table and arithmetic helpers shared by the
// bouncing body integrator.
// ---------------------------------------------------------------------------
package bbi_pkg;

    localparam int QW  = 32;  // Q16.16 word width
    localparam int HW  = 17;  // half extent width
    localparam int DTW = 16;  // time step width (Q0.16)
    localparam int PW  = 64;  // full product width
    localparam int PCW = 4;   // microcode address width
    localparam int CIW = 2;   // config index width

    localparam logic signed [QW-1:0] GRAVITY_RST = -32'sd642253;
    localparam logic signed [QW-1:0] K_BOUNCE_Y  = -32'sd52429;
    localparam logic signed [QW-1:0] K_BOUNCE_X  = -32'sd58982;
    localparam logic signed [QW-1:0] K_DECAY_X   = 32'sd65503;
    localparam logic signed [QW:0]   Q_ONE       = 33'sd65536;

    localparam logic [CIW-1:0] CFG_GRAVITY     = 2'd0;
    localparam logic [CIW-1:0] CFG_HALF_WIDTH  = 2'd1;
    localparam logic [CIW-1:0] CFG_HALF_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } seq_state_t;

    // multiplier operand selects
    typedef enum logic [1:0] {
        A_GRAV,
        A_VX,
        A_VYT,
        A_VXT
    } mul_a_t;

    typedef enum logic [1:0] {
        B_DT,
        B_KBY,
        B_KBX,
        B_KDX
    } mul_b_t;

    // write-back operations, all consume the rounded product
    typedef enum logic [2:0] {
        WB_NONE,
        WB_VY,      // vyt = sat(vy + m)
        WB_TX,      // tx  = sat(px + m)
        WB_TY,      // ty  = sat(py + m)
        WB_VXN,     // vxn = m (decayed vx)
        WB_BOUNCE,  // vertical wall handling, latch both hit flags
        WB_VXT      // vxt = m (reflected vx)
    } wb_op_t;

    typedef enum logic [1:0] {
        END_NO,
        END_ALWAYS,
        END_IF_NO_SIDE
    } end_op_t;

    typedef struct packed {
        mul_a_t  a_sel;
        mul_b_t  b_sel;
        wb_op_t  wb;
        end_op_t fin;
    } uword_t;

    // datapath control from the sequencer
    typedef struct packed {
        mul_a_t a_sel;
        mul_b_t b_sel;
        wb_op_t wb;
        logic   init;
        logic   load;
        logic   commit;
    } dp_ctl_t;

    // A product issued at one step passes through prod_reg and mq_reg before write-back can use it.
    function automatic uword_t ucode(input logic [PCW-1:0] pc);
        uword_t w;
        begin
            w = '{a_sel: A_GRAV, b_sel: B_DT, wb: WB_NONE, fin: END_NO};
            case (pc)
                4'd0:  w = '{A_GRAV, B_DT,  WB_NONE,   END_NO};
                4'd1:  w = '{A_VX,   B_DT,  WB_NONE,   END_NO};
                4'd2:  w = '{A_VX,   B_KDX, WB_VY,     END_NO};
                4'd3:  w = '{A_VYT,  B_DT,  WB_TX,     END_NO};
                4'd4:  w = '{A_VYT,  B_KBY, WB_VXN,    END_NO};
                4'd5:  w = '{A_VX,   B_KBX, WB_TY,     END_NO};
                4'd6:  w = '{A_GRAV, B_DT,  WB_BOUNCE, END_IF_NO_SIDE};
                4'd7:  w = '{A_GRAV, B_DT,  WB_VXT,    END_NO};
                4'd8:  w = '{A_VXT,  B_DT,  WB_NONE,   END_NO};
                4'd9:  w = '{A_VYT,  B_DT,  WB_NONE,   END_NO};
                4'd10: w = '{A_VXT,  B_KDX, WB_TX,     END_NO};
                4'd11: w = '{A_GRAV, B_DT,  WB_TY,     END_NO};
                4'd12: w = '{A_GRAV, B_DT,  WB_VXN,    END_ALWAYS};
                default: w = '{A_GRAV, B_DT, WB_NONE,  END_ALWAYS};
            endcase
            return w;
        end
    endfunction

    function automatic logic signed [QW-1:0] sat33(input logic signed [QW:0] v);
        logic signed [QW-1:0] r;
        begin
            if (v[QW] == v[QW-1])
                r = v[QW-1:0];
            else if (v[QW])
                r = {1'b1, {(QW-1){1'b0}}};
            else
                r = {1'b0, {(QW-1){1'b1}}};
            return r;
        end
    endfunction

    function automatic logic signed [QW-1:0] sat48(input logic signed [47:0] v);
        logic signed [QW-1:0] r;
        begin
            if (v[47:QW-1] == {(48-QW+1){v[47]}})
                r = v[QW-1:0];
            else if (v[47])
                r = {1'b1, {(QW-1){1'b0}}};
            else
                r = {1'b0, {(QW-1){1'b1}}};
            return r;
        end
    endfunction

    function automatic logic signed [QW-1:0] sat_add(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
        logic signed [QW:0] s;
        begin
            s = {a[QW-1], a} + {b[QW-1], b};
            return sat33(s);
        end
    endfunction

    // |t| + h > 1.0, without overflow
    function automatic logic wall_hit(input logic signed [QW-1:0] t,
                                      input logic [HW-1:0] h);
        logic [QW:0]   ext;
        logic [QW:0]   mag;
        logic [QW+1:0] s;
        begin
            ext = {t[QW-1], t};
            mag = t[QW-1] ? (~ext + 33'd1) : ext;
            s   = {1'b0, mag} + {{(QW+2-HW){1'b0}}, h};
            return s > 34'd65536;
        end
    endfunction

    // wall position: top is 1.0 - h, bottom is h - 1.0
    function automatic logic signed [QW-1:0] wall_pos(input logic top,
                                                      input logic [HW-1:0] h);
        logic signed [QW:0] hx;
        logic signed [QW:0] r;
        begin
            hx = {{(QW+1-HW){1'b0}}, h};
            r  = top ? (Q_ONE - hx) : (hx - Q_ONE);
            return r[QW-1:0];
        end
    endfunction

endpackage

### src/bouncing_body_integrator_top.sv
// ---------------------------------------------------------------------------
// bouncing_body_integrator_top
// Advances one body in the unit box per step word, or loads its state.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  --------  ---------------------  -------------------------------------------
//  in        in_valid / in_stall    action, step_time, load_pos_x/y, load_vel_x/y
//  out       out_valid / out_stall  pos_x/y, vel_x/y, hit_vertical_wall, hit_side_wall
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (gravity, half_width,
//                                   half_height)
//
//  A step word's result is registered by a commit after seven microcode steps
//  when no side wall is hit and after thirteen when one is; a load word goes
//  straight to the commit. The next word is taken in the cycle after the
//  commit. The step count is set by the single shared 32x32 multiplier,
//  whose product passes through prod_reg and mq_reg before it is used.
//  One word is in flight at a time; the next one is taken once the result is
//  in the output register, even while that register is stalled.
//  Reset clears the body state to zero and loads the register defaults.
//  cfg_ready is always high; write config only while the block is idle.
// ---------------------------------------------------------------------------
module bouncing_body_integrator_top
    import bbi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // step / load words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [DTW-1:0]       step_time,
    input  logic signed [QW-1:0] load_pos_x,
    input  logic signed [QW-1:0] load_pos_y,
    input  logic signed [QW-1:0] load_vel_x,
    input  logic signed [QW-1:0] load_vel_y,
    // results
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [QW-1:0] pos_x,
    output logic signed [QW-1:0] pos_y,
    output logic signed [QW-1:0] vel_x,
    output logic signed [QW-1:0] vel_y,
    output logic                 hit_vertical_wall,
    output logic                 hit_side_wall,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CIW-1:0]       cfg_index,
    input  logic [QW-1:0]        cfg_data
);

    seq_state_t            state_reg, state_next;
    logic [PCW-1:0]        upc_reg, upc_next;
    uword_t                uw;
    dp_ctl_t               ctl;
    logic                  side_hit;
    logic                  finish;

    logic signed [QW-1:0]  gravity_reg;
    logic [HW-1:0]         half_width_reg;
    logic [HW-1:0]         half_height_reg;

    logic signed [QW-1:0]  new_pos_x, new_pos_y, new_vel_x, new_vel_y;
    logic                  new_hit_v, new_hit_s;

    logic                  out_valid_reg, out_valid_next;
    logic signed [QW-1:0]  pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic                  hit_v_out_reg, hit_s_out_reg;

    // ---- config registers ----
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg     <= GRAVITY_RST;
            half_width_reg  <= '0;
            half_height_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRAVITY:     gravity_reg     <= cfg_data;
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_data[HW-1:0];
                CFG_HALF_HEIGHT: half_height_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // ---- microcode sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            upc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        upc_next   = upc_reg;
        uw         = ucode(upc_reg);
        finish     = 1'b0;
        ctl        = '{a_sel: A_GRAV, b_sel: B_DT, wb: WB_NONE,
                       init: 1'b0, load: 1'b0, commit: 1'b0};
        in_stall   = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action)
                    begin
                        ctl.load   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        ctl.init   = 1'b1;
                        upc_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                ctl.a_sel = uw.a_sel;
                ctl.b_sel = uw.b_sel;
                ctl.wb    = uw.wb;
                finish    = (uw.fin == END_ALWAYS) ||
                            ((uw.fin == END_IF_NO_SIDE) && !side_hit);
                if (finish)
                    state_next = ST_DONE;
                else
                    upc_next = upc_reg + 1'b1;
            end
            ST_DONE:
            begin
                // move result into the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    bbi_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .step_time   (step_time),
        .load_pos_x  (load_pos_x),
        .load_pos_y  (load_pos_y),
        .load_vel_x  (load_vel_x),
        .load_vel_y  (load_vel_y),
        .gravity     (gravity_reg),
        .half_width  (half_width_reg),
        .half_height (half_height_reg),
        .side_hit    (side_hit),
        .new_pos_x   (new_pos_x),
        .new_pos_y   (new_pos_y),
        .new_vel_x   (new_vel_x),
        .new_vel_y   (new_vel_y),
        .new_hit_v   (new_hit_v),
        .new_hit_s   (new_hit_s)
    );

    // ---- output register ----
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            pos_x_reg     <= new_pos_x;
            pos_y_reg     <= new_pos_y;
            vel_x_reg     <= new_vel_x;
            vel_y_reg     <= new_vel_y;
            hit_v_out_reg <= new_hit_v;
            hit_s_out_reg <= new_hit_s;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pos_x             = pos_x_reg;
    assign pos_y             = pos_y_reg;
    assign vel_x             = vel_x_reg;
    assign vel_y             = vel_y_reg;
    assign hit_vertical_wall = hit_v_out_reg;
    assign hit_side_wall     = hit_s_out_reg;

endmodule

### src/bbi_datapath.sv
// ---------------------------------------------------------------------------
// bbi_datapath
// Shared multiplier with rounding stage, working registers and body state,
// driven one control word per cycle by the sequencer.
// ---------------------------------------------------------------------------
module bbi_datapath
    import bbi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_ctl_t               ctl,
    input  logic [DTW-1:0]        step_time,
    input  logic signed [QW-1:0]  load_pos_x,
    input  logic signed [QW-1:0]  load_pos_y,
    input  logic signed [QW-1:0]  load_vel_x,
    input  logic signed [QW-1:0]  load_vel_y,
    input  logic signed [QW-1:0]  gravity,
    input  logic [HW-1:0]         half_width,
    input  logic [HW-1:0]         half_height,
    output logic                  side_hit,
    output logic signed [QW-1:0]  new_pos_x,
    output logic signed [QW-1:0]  new_pos_y,
    output logic signed [QW-1:0]  new_vel_x,
    output logic signed [QW-1:0]  new_vel_y,
    output logic                  new_hit_v,
    output logic                  new_hit_s
);

    logic [DTW-1:0]        dt_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [PW-1:0]  prod_next;
    logic signed [QW-1:0]  mq_reg;
    logic signed [QW-1:0]  mq_next;
    logic signed [QW-1:0]  op_a;
    logic signed [QW-1:0]  op_b;
    logic signed [PW-1:0]  rsum;

    // body state
    logic signed [QW-1:0]  px_reg, py_reg, vx_reg, vy_reg;
    // working registers
    logic signed [QW-1:0]  tx_reg, ty_reg, vyt_reg, vxt_reg, vxn_reg;
    logic                  hit_v_reg, hit_s_reg;
    logic                  vert_hit;

    always_comb
    begin
        case (ctl.a_sel)
            A_GRAV:  op_a = gravity;
            A_VX:    op_a = vx_reg;
            A_VYT:   op_a = vyt_reg;
            A_VXT:   op_a = vxt_reg;
            default: op_a = gravity;
        endcase
        case (ctl.b_sel)
            B_DT:    op_b = $signed({{(QW-DTW){1'b0}}, dt_reg});
            B_KBY:   op_b = K_BOUNCE_Y;
            B_KBX:   op_b = K_BOUNCE_X;
            B_KDX:   op_b = K_DECAY_X;
            default: op_b = K_DECAY_X;
        endcase
        prod_next = op_a * op_b;
        // round half up, floor shift, saturate
        rsum      = prod_reg + 64'sd32768;
        mq_next   = sat48(rsum[PW-1:16]);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        mq_reg   <= mq_next;
    end

    assign side_hit = wall_hit(tx_reg, half_width);
    assign vert_hit = wall_hit(ty_reg, half_height);

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            dt_reg    <= step_time;
            hit_v_reg <= 1'b0;
            hit_s_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            tx_reg    <= load_pos_x;
            ty_reg    <= load_pos_y;
            vxn_reg   <= load_vel_x;
            vyt_reg   <= load_vel_y;
            hit_v_reg <= 1'b0;
            hit_s_reg <= 1'b0;
        end
        else
        begin
            case (ctl.wb)
                WB_VY:   vyt_reg <= sat_add(vy_reg, mq_reg);
                WB_TX:   tx_reg  <= sat_add(px_reg, mq_reg);
                WB_TY:   ty_reg  <= sat_add(py_reg, mq_reg);
                WB_VXN:  vxn_reg <= mq_reg;
                WB_VXT:  vxt_reg <= mq_reg;
                WB_BOUNCE:
                begin
                    hit_v_reg <= vert_hit;
                    hit_s_reg <= side_hit;
                    if (vert_hit)
                    begin
                        if (vyt_reg != '0)
                        begin
                            vyt_reg <= mq_reg;
                            ty_reg  <= wall_pos(!vyt_reg[QW-1], half_height);
                        end
                        else
                        begin
                            // still body: clamp to the wall it lies beyond
                            ty_reg  <= wall_pos(!ty_reg[QW-1] && (ty_reg != '0),
                                                half_height);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= '0;
            py_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
        end
        else if (ctl.commit)
        begin
            px_reg <= tx_reg;
            py_reg <= ty_reg;
            vx_reg <= vxn_reg;
            vy_reg <= vyt_reg;
        end
    end

    assign new_pos_x = tx_reg;
    assign new_pos_y = ty_reg;
    assign new_vel_x = vxn_reg;
    assign new_vel_y = vyt_reg;
    assign new_hit_v = hit_v_reg;
    assign new_hit_s = hit_s_reg;

endmodule

### src/bbi_checker.sv
// ---------------------------------------------------------------------------
// bbi_checker
// Port-level checks on the integrator, bound to the top level.
// ---------------------------------------------------------------------------
module bbi_checker
    import bbi_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic signed [QW-1:0] pos_x,
    input logic signed [QW-1:0] vel_y
);

    // one word at a time: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous word still in flight");

    // a result only appears after a word has been worked on
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a word in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(pos_x) && $stable(vel_y)))
        else $error("result changed while stalled");

endmodule

bind bouncing_body_integrator_top bbi_checker u_bbi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pos_x     (pos_x),
    .vel_y     (vel_y)
);

### test/tb_bouncing_body_integrator_top.sv
// ---------------------------------------------------------------------------
// tb_bouncing_body_integrator_top
// Self-checking bench for the bouncing body integrator. A scoreboard holds
// its own integer model of the body and the register file, predicts one
// result word per accepted step or load word, and compares the block's
// results with it in order. Traffic is bursty on the input and stalled on a
// pattern of its own on the output, over several register settings.
// ---------------------------------------------------------------------------
package bbi_tb_pkg;

    localparam logic ACT_STEP = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam longint Q_UNIT    = 64'sd65536;
    localparam longint REFLECT_Y = -64'sd52429;  // -0.80
    localparam longint REFLECT_X = -64'sd58982;  // -0.90
    localparam longint DRAG_X    = 64'sd65503;   // 0.9995
    localparam longint Q32_MAX   = 64'sd2147483647;
    localparam longint Q32_MIN   = -64'sd2147483648;

    typedef struct packed {
        logic               action;
        logic [15:0]        step_time;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } body_word_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               hit_v;
        logic               hit_s;
    } body_result_t;

    function automatic longint q_sat(input longint v);
        if (v > Q32_MAX)
            return Q32_MAX;
        if (v < Q32_MIN)
            return Q32_MIN;
        return v;
    endfunction

    // exact product, +half LSB, floor back to Q16.16, saturate
    function automatic longint q_mul(input longint a, input longint b);
        return q_sat((a * b + 64'sd32768) >>> 16);
    endfunction

    function automatic longint q_abs(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    class body_scoreboard;
        logic signed [31:0] gravity_q;
        logic [16:0]        half_w;
        logic [16:0]        half_h;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        body_result_t       expected_q[$];
        int unsigned        mismatches;
        int unsigned        results_seen;

        function new();
            gravity_q    = -32'sd642253;
            half_w       = '0;
            half_h       = '0;
            pos_x        = '0;
            pos_y        = '0;
            vel_x        = '0;
            vel_y        = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_register(input logic [bbi_pkg::CIW-1:0] idx,
                                     input logic [31:0] data);
            case (idx)
                bbi_pkg::CFG_GRAVITY:     gravity_q = data;
                bbi_pkg::CFG_HALF_WIDTH:  half_w = data[16:0];
                bbi_pkg::CFG_HALF_HEIGHT: half_h = data[16:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // advance the body model by one accepted word and queue the result
        function void note_word(input body_word_t w);
            longint       dt;
            longint       hw;
            longint       hh;
            longint       vx;
            longint       vy;
            longint       vy_moved;
            longint       tx;
            longint       ty;
            body_result_t r;
            r.hit_v = 1'b0;
            r.hit_s = 1'b0;
            if (w.action == ACT_LOAD)
            begin
                pos_x = w.px;
                pos_y = w.py;
                vel_x = w.vx;
                vel_y = w.vy;
            end
            else
            begin
                dt = longint'(w.step_time);
                hw = longint'(half_w);
                hh = longint'(half_h);
                vx = longint'(vel_x);
                vy = q_sat(longint'(vel_y) + q_mul(longint'(gravity_q), dt));
                vy_moved = vy;
                tx = q_sat(longint'(pos_x) + q_mul(vx, dt));
                ty = q_sat(longint'(pos_y) + q_mul(vy, dt));
                if (q_abs(ty) + hh > Q_UNIT)
                begin
                    r.hit_v = 1'b1;
                    if (vy_moved != 0)
                    begin
                        vy = q_mul(vy, REFLECT_Y);
                        ty = (vy_moved > 0) ? Q_UNIT - hh : hh - Q_UNIT;
                    end
                    else
                    begin
                        // still body: clamp to the wall it actually lies beyond
                        vy = 0;
                        ty = (ty > 0) ? Q_UNIT - hh : hh - Q_UNIT;
                    end
                end
                if (q_abs(tx) + hw > Q_UNIT)
                begin
                    r.hit_s = 1'b1;
                    vx = q_mul(vx, REFLECT_X);
                    tx = q_sat(longint'(pos_x) + q_mul(vx, dt));
                    ty = q_sat(longint'(pos_y) + q_mul(vy, dt));
                end
                pos_x = tx[31:0];
                pos_y = ty[31:0];
                vel_x = 32'(q_mul(vx, DRAG_X));
                vel_y = vy[31:0];
            end
            r.pos_x = pos_x;
            r.pos_y = pos_y;
            r.vel_x = vel_x;
            r.vel_y = vel_y;
            expected_q.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input body_result_t act);
            body_result_t exp_r;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with nothing outstanding, expected none, actual %h",
                         $time, act);
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("pos_x", exp_r.pos_x, act.pos_x);
            compare_field("pos_y", exp_r.pos_y, act.pos_y);
            compare_field("vel_x", exp_r.vel_x, act.vel_x);
            compare_field("vel_y", exp_r.vel_y, act.vel_y);
            compare_field("hit_vertical_wall", 32'(exp_r.hit_v), 32'(act.hit_v));
            compare_field("hit_side_wall", 32'(exp_r.hit_s), 32'(act.hit_s));
        endfunction
    endclass

endpackage

module tb_bouncing_body_integrator_top;
    import bbi_pkg::*;
    import bbi_tb_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int LONG_HOLD      = 400;   // receiver hold-off, cycles
    localparam int HOLD_AFTER     = 260;   // results seen before the hold-off
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 24;    // wait after the last result is checked
    localparam int PHASE_WORDS    = 140;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 action = ACT_STEP;
    logic [DTW-1:0]       step_time = '0;
    logic signed [QW-1:0] load_pos_x = '0;
    logic signed [QW-1:0] load_pos_y = '0;
    logic signed [QW-1:0] load_vel_x = '0;
    logic signed [QW-1:0] load_vel_y = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [QW-1:0] pos_x;
    logic signed [QW-1:0] pos_y;
    logic signed [QW-1:0] vel_x;
    logic signed [QW-1:0] vel_y;
    logic                 hit_vertical_wall;
    logic                 hit_side_wall;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CIW-1:0]       cfg_index = '0;
    logic [QW-1:0]        cfg_data = '0;

    body_scoreboard sb = new();
    int             burst_left = 0;
    int             idle_cycles = 0;

    bouncing_body_integrator_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .step_time         (step_time),
        .load_pos_x        (load_pos_x),
        .load_pos_y        (load_pos_y),
        .load_vel_x        (load_vel_x),
        .load_vel_y        (load_vel_y),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .vel_x             (vel_x),
        .vel_y             (vel_y),
        .hit_vertical_wall (hit_vertical_wall),
        .hit_side_wall     (hit_side_wall),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 clk = ~clk;

    // Monitors sample at the edge, so they see the values held through the
    // cycle before it; all drives are nonblocking, so there is no race.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_word('{action, step_time, load_pos_x, load_pos_y,
                           load_vel_x, load_vel_y});
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{pos_x, pos_y, vel_x, vel_y,
                              hit_vertical_wall, hit_side_wall});
    end

    // Watchdog: counts cycles without any handshake on any channel.
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: segments of random length, each with its own stall density
    // (none, light, half, heavy). Once, mid-run, it holds off for a long
    // stretch so the result register fills and the input backs up.
    initial
    begin
        int unsigned mode;
        int unsigned span;
        bit          held;
        held = 1'b0;
        @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            if (!held && sb.results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            repeat (span)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 1);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // --- word builders: unused fields carry random bits -----------------------

    function automatic body_word_t step_word(input logic [15:0] dt);
        body_word_t w;
        w = '{ACT_STEP, dt, $urandom, $urandom, $urandom, $urandom};
        return w;
    endfunction

    function automatic body_word_t load_word(input logic signed [31:0] px,
                                             input logic signed [31:0] py,
                                             input logic signed [31:0] vx,
                                             input logic signed [31:0] vy);
        body_word_t w;
        w = '{ACT_LOAD, 16'($urandom), px, py, vx, vy};
        return w;
    endfunction

    // Mostly short steps of a body loaded inside the box with sensible speed,
    // so it actually falls and bounces; the rest are wild loads and odd steps.
    function automatic body_word_t random_word();
        body_word_t  w;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        w = step_word(16'($urandom_range(0, 4096)));
        if (pick < 8)
        begin
            w = load_word($urandom_range(0, 131072) - 32'd65536,
                          $urandom_range(0, 131072) - 32'd65536,
                          $urandom_range(0, 655360) - 32'd327680,
                          $urandom_range(0, 655360) - 32'd327680);
            if ($urandom_range(0, 3) == 0)
                w.vy = '0;
        end
        else if (pick < 11)
            w = load_word($urandom, $urandom, $urandom, $urandom);
        else if (pick < 14)
            w.step_time = 16'($urandom);
        else if (pick < 17)
            w.step_time = '0;
        return w;
    endfunction

    // --- drivers ---------------------------------------------------------------

    // Offer one word and wait for it to be taken. Valid stays up inside a
    // burst; a burst ends with a random gap.
    task automatic offer_word(input body_word_t w);
        action     <= w.action;
        step_time  <= w.step_time;
        load_pos_x <= w.px;
        load_pos_y <= w.py;
        load_vel_x <= w.vx;
        load_vel_y <= w.vy;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    // cfg_valid is left high for back-to-back writes; caller lowers it
    task automatic write_cfg(input logic [CIW-1:0] idx, input logic [QW-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, data);
    endtask

    // Stop offering, wait for every outstanding result, then let the block
    // settle so nothing is still in flight.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [QW-1:0] g, input logic [16:0] hw,
                             input logic [16:0] hh, input int n);
        drain();
        write_cfg(CFG_GRAVITY, g);
        write_cfg(CFG_HALF_WIDTH, {15'd0, hw});
        write_cfg(CFG_HALF_HEIGHT, {15'd0, hh});
        cfg_valid <= 1'b0;
        @(posedge clk);
        repeat (n) offer_word(random_word());
    endtask

    // --- sequence --------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under reset settings (gravity -9.8, point body).
        offer_word(step_word(16'd0));          // nothing moves
        offer_word(step_word(16'hFFFF));       // long fall through the floor
        offer_word(load_word(32'sh7FFFFFFF, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF, 32'sh7FFFFFFF));
        offer_word(step_word(16'hFFFF));       // saturating sums and products
        offer_word(load_word(32'sh80000000, 32'sh80000000,
                             32'sh80000000, 32'sh80000000));
        offer_word(step_word(16'hFFFF));
        offer_word(step_word(16'd0));
        // rising body goes through the ceiling
        offer_word(load_word(32'sd0, 32'sd58982, 32'sd0, 32'sd327680));
        offer_word(step_word(16'd6554));
        // still body beyond the ceiling, then beyond the floor
        offer_word(load_word(32'sd0, 32'sd98304, 32'sd0, 32'sd0));
        offer_word(step_word(16'd0));
        offer_word(load_word(32'sd0, -32'sd98304, 32'sd0, 32'sd0));
        offer_word(step_word(16'd0));
        // right wall, left wall, then a corner with both walls at once
        offer_word(load_word(32'sd62259, 32'sd0, 32'sd131072, 32'sd0));
        offer_word(step_word(16'd6554));
        offer_word(load_word(-32'sd62259, 32'sd0, -32'sd131072, 32'sd0));
        offer_word(step_word(16'd6554));
        offer_word(load_word(32'sd62259, -32'sd62259, 32'sd131072, -32'sd196608));
        offer_word(step_word(16'd6554));
        offer_word(load_word(32'sd0, 32'sd0, 32'sd0, 32'sd0));
        offer_word(step_word(16'd1092));

        // Random phases across settings, extremes included; extents above one
        // unit put the clamp targets outside the box.
        run_phase(-32'sd642253, 17'd3277, 17'd6554, PHASE_WORDS);
        run_phase(32'sd0, 17'd65536, 17'd65536, PHASE_WORDS);
        run_phase(32'sh7FFFFFFF, 17'd0, 17'd0, PHASE_WORDS);
        run_phase(32'sh80000000, 17'd131071, 17'd70000, PHASE_WORDS);
        run_phase(32'sd655360, 17'd1000, 17'd20000, PHASE_WORDS);
        run_phase($urandom, 17'($urandom_range(0, 65536)),
                  17'($urandom_range(0, 65536)), PHASE_WORDS);
        run_phase(-32'sd642253, 17'd0, 17'd65536, PHASE_WORDS);
        drain();

        if (sb.pending() != 0)
            $display("%0t: %0d result words outstanding, expected 0",
                     $time, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
